/* hdl/tpt_pkg.sv */
// Shared types and constants for the two-pointer touch tracker.
`timescale 1ns / 1ps
package tpt_pkg;

  localparam int unsigned POINTERS   = 2;
  localparam int unsigned COORD_BITS = 16;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    OpPress   = 2'd0,
    OpDrag    = 2'd1,
    OpRelease = 2'd2,
    OpOther   = 2'd3
  } opcode_e;

  // slot code: pointer 0, pointer 1, or empty
  typedef logic [1:0] slot_t;
  localparam slot_t SlotNone = 2'd2;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    opcode_e opcode;
    logic    pointer_id;
    coord_t  pos_x;
    coord_t  pos_y;
    logic    on_target;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       repeat_press;
    logic [1:0] touch_count;
    coord_t     lead_x;
    coord_t     lead_y;
    coord_t     follow_x;
    coord_t     follow_y;
    coord_t     lead_start_x;
    coord_t     lead_start_y;
    coord_t     follow_start_x;
    coord_t     follow_start_y;
  } out_item_t;

endpackage

/* hdl/tpt_core.sv */
// Pointer state registers and the per-item update and result logic.
`timescale 1ns / 1ps
module tpt_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  tpt_pkg::in_item_t item_i,
  output tpt_pkg::out_item_t result_o
);
  import tpt_pkg::*;

  logic [POINTERS-1:0]         held_q, held_d;
  logic [POINTERS-1:0]         aimed_q, aimed_d;
  point_t [POINTERS-1:0]       cur_q, cur_d;
  point_t [POINTERS-1:0]       start_q, start_d;
  logic [1:0]                  count_q, count_d;
  slot_t                       first_q, first_d;
  slot_t                       second_q, second_d;

  logic   id;
  logic   ev_ok;
  logic   outside;
  logic   lead_id;
  logic   follow_id;
  point_t pos;

  assign id      = item_i.pointer_id;
  assign outside = |(held_q & ~aimed_q);
  assign pos     = '{x: item_i.pos_x, y: item_i.pos_y};

  always_comb begin
    ev_ok    = 1'b1;
    held_d   = held_q;
    aimed_d  = aimed_q;
    cur_d    = cur_q;
    start_d  = start_q;
    count_d  = count_q;
    first_d  = first_q;
    second_d = second_q;
    case (item_i.opcode)
      OpPress: begin
        ev_ok = ~held_q[id];
        if (ev_ok) begin
          if (count_q == 2'd0) begin
            first_d = {1'b0, id};
          end else if (count_q == 2'd1) begin
            second_d = {1'b0, id};
          end
          cur_d[id]   = pos;
          start_d[id] = pos;
          held_d[id]  = 1'b1;
          aimed_d[id] = item_i.on_target & ~outside;
          count_d     = count_q + 2'd1;
        end
      end
      OpDrag: begin
        ev_ok = held_q[id];
        if (ev_ok) begin
          cur_d[id] = pos;
        end
      end
      OpRelease: begin
        ev_ok = held_q[id];
        if (ev_ok) begin
          if (count_q == 2'd1) begin
            first_d = SlotNone;
          end else if (count_q == 2'd2) begin
            first_d  = {1'b0, ~id};
            second_d = SlotNone;
          end
          held_d[id] = 1'b0;
          count_d    = count_q - 2'd1;
        end
      end
      default: ev_ok = 1'b1;
    endcase
  end

  assign lead_id   = (first_d == SlotNone) ? 1'b0 : first_d[0];
  assign follow_id = (second_d == SlotNone) ? 1'b1 : second_d[0];

  always_comb begin
    result_o.accepted       = ev_ok & aimed_d[id];
    result_o.repeat_press   = ~ev_ok & (item_i.opcode == OpPress);
    result_o.touch_count    = count_d;
    result_o.lead_x         = cur_d[lead_id].x;
    result_o.lead_y         = cur_d[lead_id].y;
    result_o.follow_x       = cur_d[follow_id].x;
    result_o.follow_y       = cur_d[follow_id].y;
    result_o.lead_start_x   = start_d[lead_id].x;
    result_o.lead_start_y   = start_d[lead_id].y;
    result_o.follow_start_x = start_d[follow_id].x;
    result_o.follow_start_y = start_d[follow_id].y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= '0;
      aimed_q  <= '0;
      cur_q    <= '0;
      start_q  <= '0;
      count_q  <= 2'd0;
      first_q  <= SlotNone;
      second_q <= SlotNone;
    end else if (fire_i) begin
      held_q   <= held_d;
      aimed_q  <= aimed_d;
      cur_q    <= cur_d;
      start_q  <= start_d;
      count_q  <= count_d;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

endmodule

/* hdl/two_touch_pointer_tracker_unit.sv */
// Top level: input register, tracker core and result register.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o  | in_item_i  (in_item_t)
//   out     | output    | out_valid_o/out_stall_i| out_item_o (out_item_t)
//
// One item per cycle while the output is not stalled; a taken item passes
// through the input register, then the core update into the result register.
// Reset clears all pointer state, empties both order slots and the pipeline.
// A stalled result holds the result register; the input register then holds
// its item and in_stall_o rises until the result is taken.
`timescale 1ns / 1ps
module two_touch_pointer_tracker_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tpt_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tpt_pkg::out_item_t out_item_o
);
  import tpt_pkg::*;

  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t result;
  logic      adv;
  logic      fire;
  logic      in_acc;

  assign adv        = ~out_valid_q | ~out_stall_i;
  assign fire       = s1_valid_q & adv;
  assign in_stall_o = s1_valid_q & ~adv;
  assign in_acc     = in_valid_i & ~in_stall_o;

  tpt_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (s1_item_q),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_item_i;
    end
    if (fire) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* bench/tb.sv */
// Testbench for the two-pointer touch tracker: directed and random event streams, scoreboarded.
`timescale 1ns / 1ps
module tb;
  import tpt_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  two_touch_pointer_tracker_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // tracker state mirror
  logic       ptr_down  [2];
  logic       ptr_aimed [2];
  point_t     ptr_cur   [2];
  point_t     ptr_start [2];
  logic [1:0] down_count;
  slot_t      lead_slot;
  slot_t      follow_slot;

  out_item_t  touch_q[$];
  int         errors = 0;
  int         n_events = 0;
  int         n_checked = 0;
  int         n_rejected = 0;
  int         n_blocked = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  initial begin
    for (int i = 0; i < 2; i++) begin
      ptr_down[i]  = 1'b0;
      ptr_aimed[i] = 1'b0;
      ptr_cur[i]   = '0;
      ptr_start[i] = '0;
    end
    down_count  = '0;
    lead_slot   = SlotNone;
    follow_slot = SlotNone;
  end

  function automatic out_item_t track_event(in_item_t ev);
    out_item_t r;
    logic      ok;
    logic      hit;
    logic      rep;
    logic      tgt;
    logic      outside;
    int        id;
    int        lead;
    int        follow;
    id  = ev.pointer_id;
    ok  = 1'b1;
    hit = 1'b0;
    rep = 1'b0;
    if (ev.opcode == OpPress && ptr_down[id]) ok = 1'b0;
    else if ((ev.opcode == OpDrag || ev.opcode == OpRelease) && !ptr_down[id]) ok = 1'b0;
    if (ok) begin
      if (ev.opcode == OpPress) begin
        if (down_count == 2'd0) lead_slot = {1'b0, ev.pointer_id};
        else if (down_count == 2'd1) follow_slot = {1'b0, ev.pointer_id};
      end else if (ev.opcode == OpRelease) begin
        if (down_count == 2'd1) begin
          lead_slot = SlotNone;
        end else if (down_count == 2'd2) begin
          lead_slot   = {1'b0, ~ev.pointer_id};
          follow_slot = SlotNone;
        end
      end
      outside = (ptr_down[0] && !ptr_aimed[0]) || (ptr_down[1] && !ptr_aimed[1]);
      case (ev.opcode)
        OpPress: begin
          tgt = ev.on_target && !outside;
          if (ev.on_target && outside) n_blocked++;
          ptr_cur[id]   = '{x: ev.pos_x, y: ev.pos_y};
          ptr_start[id] = '{x: ev.pos_x, y: ev.pos_y};
          ptr_down[id]  = 1'b1;
          ptr_aimed[id] = tgt;
          down_count    = down_count + 2'd1;
        end
        OpDrag: begin
          ptr_cur[id] = '{x: ev.pos_x, y: ev.pos_y};
        end
        OpRelease: begin
          ptr_down[id] = 1'b0;
          down_count   = down_count - 2'd1;
        end
        default: ;
      endcase
      hit = ptr_aimed[id];
    end else begin
      rep = (ev.opcode == OpPress);
      n_rejected++;
    end
    lead   = (lead_slot == 2'd0 || lead_slot == 2'd1) ? lead_slot[0] : 0;
    follow = (follow_slot == 2'd0 || follow_slot == 2'd1) ? follow_slot[0] : 1;
    r.accepted       = hit;
    r.repeat_press   = rep;
    r.touch_count    = down_count;
    r.lead_x         = ptr_cur[lead].x;
    r.lead_y         = ptr_cur[lead].y;
    r.follow_x       = ptr_cur[follow].x;
    r.follow_y       = ptr_cur[follow].y;
    r.lead_start_x   = ptr_start[lead].x;
    r.lead_start_y   = ptr_start[lead].y;
    r.follow_start_x = ptr_start[follow].x;
    r.follow_start_y = ptr_start[follow].y;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  task automatic check_result(out_item_t got, out_item_t want);
    compare_field("accepted", got.accepted, want.accepted);
    compare_field("repeat_press", got.repeat_press, want.repeat_press);
    compare_field("touch_count", got.touch_count, want.touch_count);
    compare_field("lead_x", got.lead_x, want.lead_x);
    compare_field("lead_y", got.lead_y, want.lead_y);
    compare_field("follow_x", got.follow_x, want.follow_x);
    compare_field("follow_y", got.follow_y, want.follow_y);
    compare_field("lead_start_x", got.lead_start_x, want.lead_start_x);
    compare_field("lead_start_y", got.lead_start_y, want.lead_start_y);
    compare_field("follow_start_x", got.follow_start_x, want.follow_start_x);
    compare_field("follow_start_y", got.follow_start_y, want.follow_start_y);
    n_checked++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (touch_q.size() == 0) report_mismatch("result with no event pending");
      else check_result(out_item_o, touch_q.pop_front());
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_event(in_item_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= ev;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    touch_q.push_back(track_event(ev));
    n_events++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (touch_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic in_item_t mk(opcode_e op, logic id, coord_t x, coord_t y, logic tgt);
    in_item_t ev;
    ev.opcode     = op;
    ev.pointer_id = id;
    ev.pos_x      = x;
    ev.pos_y      = y;
    ev.on_target  = tgt;
    return ev;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      3:       return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_event();
    in_item_t ev;
    int       id;
    int       pick;
    id            = $urandom_range(1);
    ev.pointer_id = id[0];
    ev.pos_x      = rand_coord();
    ev.pos_y      = rand_coord();
    ev.on_target  = ($urandom_range(3) != 0);
    if ($urandom_range(99) < 85) begin
      if (ptr_down[id]) begin
        pick = $urandom_range(9);
        ev.opcode = (pick < 6) ? OpDrag : (pick < 9) ? OpRelease : OpOther;
      end else begin
        ev.opcode = ($urandom_range(4) == 0) ? OpOther : OpPress;
      end
    end else begin
      ev.opcode = opcode_e'($urandom_range(3));
    end
    return ev;
  endfunction

  // fresh state: other events read zeros, drag/release on idle pointers rejected
  task automatic test_idle_after_reset();
    send_event(mk(OpOther, 1'b0, 16'sh1111, 16'sh2222, 1'b1));
    send_event(mk(OpOther, 1'b1, 16'sh8000, 16'sh7fff, 1'b0));
    send_event(mk(OpDrag, 1'b0, 16'sh0005, 16'sh0006, 1'b1));
    send_event(mk(OpRelease, 1'b1, 16'sh0007, 16'sh0008, 1'b1));
  endtask

  // press order, repeated press, lead handoff when the first pointer lifts
  task automatic test_press_order();
    send_event(mk(OpPress, 1'b0, 16'sh7fff, 16'sh8000, 1'b1));
    send_event(mk(OpPress, 1'b1, 16'sh8000, 16'sh7fff, 1'b1));
    send_event(mk(OpPress, 1'b0, 16'sh0123, 16'sh0456, 1'b1));
    send_event(mk(OpDrag, 1'b1, 16'sh0000, 16'shffff, 1'b0));
    send_event(mk(OpDrag, 1'b0, 16'shffff, 16'sh0000, 1'b1));
    send_event(mk(OpRelease, 1'b0, 16'sh5555, 16'shaaaa, 1'b0));
    send_event(mk(OpOther, 1'b0, 16'shaaaa, 16'sh5555, 1'b0));
    send_event(mk(OpRelease, 1'b1, 16'sh0001, 16'sh0002, 1'b1));
    send_event(mk(OpRelease, 1'b1, 16'sh0003, 16'sh0004, 1'b1));
    send_event(mk(OpOther, 1'b1, 16'sh0000, 16'sh0000, 1'b1));
  endtask

  // a pointer held off the control forces later presses untargeted
  task automatic test_blocked_press();
    send_event(mk(OpPress, 1'b1, 16'sh04d2, 16'shfb2e, 1'b0));
    send_event(mk(OpPress, 1'b0, 16'sh1000, 16'shf000, 1'b1));
    send_event(mk(OpDrag, 1'b0, 16'sh1001, 16'shf001, 1'b1));
    send_event(mk(OpOther, 1'b0, 16'sh0000, 16'sh0000, 1'b1));
    send_event(mk(OpRelease, 1'b1, 16'sh0000, 16'sh0000, 1'b1));
    send_event(mk(OpPress, 1'b1, 16'sh2000, 16'she000, 1'b1));
    send_event(mk(OpRelease, 1'b0, 16'sh0000, 16'sh0000, 1'b1));
    send_event(mk(OpRelease, 1'b1, 16'sh0000, 16'sh0000, 1'b1));
  endtask

  task automatic test_random(int count, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < count; i++) begin
      send_event(random_event());
      if ($urandom_range(149) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 25;
    recv_idle_pct = 61;
    test_idle_after_reset();
    test_press_order();
    test_blocked_press();
    wait_drained();
    test_random(400, 25, 61);
    test_random(400, 61, 25);
    test_random(400, 0, 0);
    if (touch_q.size() != 0) report_mismatch("events left without a result");
    $display("checked %0d results from %0d events under three idle mixes", n_checked, n_events);
    $display("%0d events rejected, %0d presses forced off target", n_rejected, n_blocked);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
